// ===== src/sdrq_pkg.sv =====
// sdrq_pkg: shared types and constants for the sstf disk request queue
// covers the request entry layout, status and request codes, and the cell control bundle
// no dependencies
`timescale 1ns / 1ps

package sdrq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int CYL_W  = 16;
  localparam int SEC_W  = 8;
  localparam int TAG_W  = 16;
  localparam int TRK_W  = 9;
  localparam int JUMP_W = 8;

  // rotational start point: sector + 1 + cylinders * jump time, below 2^24
  localparam int START_W        = 24;
  localparam int MOD_RADIX_BITS = 4;
  localparam int MOD_STEPS      = START_W / MOD_RADIX_BITS;
  localparam int MOD_CNT_W      = $clog2(MOD_STEPS);

  localparam int S_DATA_W   = 64;
  localparam int M_DATA_W   = 40;
  localparam int CFG_DATA_W = 9;

  typedef enum logic {
    CFG_SECTORS_PER_TRACK = 1'b0,
    CFG_TRACK_JUMP_TIME   = 1'b1
  } sdrq_cfg_idx_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_TAKE   = 1'b1
  } sdrq_req_type_t;

  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_TAKEN    = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_EMPTY    = 2'd3
  } sdrq_status_t;

  typedef struct packed {
    logic [CYL_W-1:0] cyl;
    logic [SEC_W-1:0] sec;
    logic [TAG_W-1:0] tag;
  } sdrq_entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_CALC   = 3'd1,
    CELL_MOD    = 3'd2,
    CELL_INSERT = 3'd3,
    CELL_TAKE   = 3'd4
  } sdrq_cell_op_t;

  typedef struct packed {
    sdrq_cell_op_t     op;
    logic [TRK_W-1:0]  trk_size;
    logic [JUMP_W-1:0] jump_time;
  } sdrq_cell_ctl_t;

endpackage

// ===== src/sdrq_cell.sv =====
// sdrq_cell: one queue slot with its own seek compare and serial modulo unit
// depends on sdrq_pkg
`timescale 1ns / 1ps

module sdrq_cell import sdrq_pkg::*; (
  input  logic           clk,
  input  sdrq_cell_ctl_t ctl,
  input  sdrq_entry_t    new_req,
  input  sdrq_entry_t    pred,
  input  sdrq_entry_t    succ,
  input  logic           valid,
  input  logic           found_in,
  output sdrq_entry_t    entry,
  output logic           found_out
);

  function automatic logic [CYL_W-1:0] abs_diff(input logic [CYL_W-1:0] a,
                                                 input logic [CYL_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [TRK_W-1:0] rot_dist(input logic [SEC_W-1:0] s,
                                                input logic [SEC_W-1:0] t,
                                                input logic [TRK_W-1:0] n);
    if (t < s) begin
      return n - TRK_W'(s - t);
    end
    return TRK_W'(t - s);
  endfunction

  logic [CYL_W-1:0]   dn;
  logic [CYL_W-1:0]   dq;
  logic [START_W-1:0] div;
  logic [SEC_W-1:0]   rem;

  logic [CYL_W-1:0]   dn_now;
  logic [CYL_W-1:0]   dq_now;
  logic [START_W-1:0] div_load;
  logic [START_W-1:0] div_next;
  logic [SEC_W-1:0]   rem_next;
  logic [TRK_W-1:0]   rd_new;
  logic [TRK_W-1:0]   rd_old;
  logic               flag;

  assign dn_now   = abs_diff(new_req.cyl, pred.cyl);
  assign dq_now   = abs_diff(entry.cyl, pred.cyl);
  assign div_load = START_W'(pred.sec) + START_W'(1)
                  + START_W'(dn_now) * START_W'(ctl.jump_time);

  // restoring remainder, MOD_RADIX_BITS dividend bits per cycle
  always_comb begin
    logic [TRK_W-1:0]   part;
    logic [SEC_W-1:0]   r;
    logic [START_W-1:0] d;
    r = rem;
    d = div;
    for (int k = 0; k < MOD_RADIX_BITS; k++) begin
      part = {r, d[START_W-1]};
      d    = d << 1;
      if (part >= ctl.trk_size) begin
        part = part - ctl.trk_size;
      end
      r = part[SEC_W-1:0];
    end
    rem_next = r;
    div_next = d;
  end

  // new request goes here if this slot is empty or farther from its predecessor
  assign rd_new    = rot_dist(rem, new_req.sec, ctl.trk_size);
  assign rd_old    = rot_dist(rem, entry.sec, ctl.trk_size);
  assign flag      = !valid || (dn < dq) || ((dn == dq) && (rd_new <= rd_old));
  assign found_out = found_in || flag;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_HOLD: begin
      end
      CELL_CALC: begin
        dn  <= dn_now;
        dq  <= dq_now;
        div <= div_load;
        rem <= '0;
      end
      CELL_MOD: begin
        div <= div_next;
        rem <= rem_next;
      end
      CELL_INSERT: begin
        if (found_in) begin
          entry <= pred;
        end else if (flag) begin
          entry <= new_req;
        end
      end
      CELL_TAKE: begin
        entry <= succ;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/sstf_disk_request_queue.sv =====
// sstf_disk_request_queue: top level of the shortest-seek-first disk request queue
// holds the control sequencer, config registers, output register and the row of cells
// depends on sdrq_pkg and sdrq_cell
`timescale 1ns / 1ps

// Shortest-seek-first disk request queue. Each request on the slave stream is
// either an insert (s_tuser = 0) carrying a cylinder, sector, tag and the
// current head position, or a take (s_tuser = 1) that pops the front entry.
// Exactly one result comes out on the master stream for every request: the
// status in m_tuser and, for a take, the removed entry in m_tdata. The queue
// is a row of QUEUE_DEPTH identical cells; slot 0 is the front and the head
// position stands in as its predecessor. On an insert every cell compares the
// new request with its own entry, both measured from the left neighbor, and
// the first cell that finds its entry farther (or finds itself empty) takes
// the new request while the cells behind it shift one place back. Equal seek
// distances are settled by rotational distance, which each cell gets from its
// own serial modulo unit working four dividend bits per cycle. An insert
// runs through a load step, the per-cell modulo by the track size and a
// shift step, while a take, a drop on a full queue and a take on an empty
// queue commit from the request step itself. The next request is accepted
// while an earlier result still waits on m_tvalid; the sequencer stalls
// only at its commit step until the output register is free. Configuration
// writes (index 0 sectors per track, index 1 track jump time) are always
// taken and should be made only while the queue is idle.
module sstf_disk_request_queue import sdrq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata from bit 0: req_cylinder[16], req_sector[8], req_tag[16],
  // head_cylinder[16], head_sector[8]
  input  logic [S_DATA_W-1:0]   s_tdata,
  // s_tuser: req_type[1]
  input  logic                  s_tuser,
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata from bit 0: out_tag[16], out_cylinder[16], out_sector[8]
  output logic [M_DATA_W-1:0]   m_tdata,
  // m_tuser: status[2]
  output logic [1:0]            m_tuser,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CALC,
    ST_MOD,
    ST_SHIFT
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [TRK_W-1:0]     spt;
  logic [JUMP_W-1:0]    tjt;

  // request held while it is worked on
  sdrq_req_type_t       item_type;
  sdrq_entry_t          new_req;
  sdrq_entry_t          head_ent;

  logic [TRK_W-1:0]     trk_size;
  logic                 full;
  logic                 empty;
  logic                 out_free;
  logic                 out_load;
  sdrq_cell_ctl_t       cell_ctl;

  sdrq_entry_t          cell_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] found;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  // output register can take a new result this cycle
  assign out_free = !m_tvalid || m_tready;
  // a result is written into the output register this cycle
  assign out_load = out_free
                  && (((state == ST_EXEC) && !((item_type == REQ_INSERT) && !full))
                      || (state == ST_SHIFT));

  // track size clamps to 1..256
  always_comb begin
    priority if (spt == '0) begin
      trk_size = TRK_W'(1);
    end else if (spt > TRK_W'(256)) begin
      trk_size = TRK_W'(256);
    end else begin
      trk_size = spt;
    end
  end

  // cell command follows the sequencer state; commits wait for a free output
  always_comb begin
    cell_ctl.trk_size  = trk_size;
    cell_ctl.jump_time = tjt;
    cell_ctl.op        = CELL_HOLD;
    unique case (state)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        if (item_type == REQ_TAKE && !empty && out_free) begin
          cell_ctl.op = CELL_TAKE;
        end
      end
      ST_CALC: begin
        cell_ctl.op = CELL_CALC;
      end
      ST_MOD: begin
        cell_ctl.op = CELL_MOD;
      end
      ST_SHIFT: begin
        if (out_free) begin
          cell_ctl.op = CELL_INSERT;
        end
      end
    endcase
  end

  // row of cells: predecessor from the left (head for slot 0), take from the right
  assign found[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    sdrq_entry_t pred_i;
    sdrq_entry_t succ_i;

    if (i == 0) begin : g_front
      assign pred_i = head_ent;
    end else begin : g_mid
      assign pred_i = cell_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_back
      assign succ_i = '0;
    end else begin : g_inner
      assign succ_i = cell_q[i+1];
    end

    sdrq_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .new_req   (new_req),
      .pred      (pred_i),
      .succ      (succ_i),
      .valid     (count > CNT_W'(i)),
      .found_in  (found[i]),
      .entry     (cell_q[i]),
      .found_out (found[i+1])
    );
  end

  // sequencer, config registers, queue fill count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      mod_cnt  <= '0;
      m_tvalid <= 1'b0;
      spt      <= TRK_W'(256);
      tjt      <= JUMP_W'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (sdrq_cfg_idx_t'(cfg_index))
          CFG_SECTORS_PER_TRACK: spt <= cfg_data;
          CFG_TRACK_JUMP_TIME:   tjt <= cfg_data[JUMP_W-1:0];
        endcase
      end

      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            item_type    <= sdrq_req_type_t'(s_tuser);
            new_req.cyl  <= s_tdata[15:0];
            new_req.sec  <= s_tdata[23:16];
            new_req.tag  <= s_tdata[39:24];
            head_ent.cyl <= s_tdata[55:40];
            head_ent.sec <= s_tdata[63:56];
            head_ent.tag <= '0;
            state        <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (item_type == REQ_INSERT && !full) begin
            state <= ST_CALC;
          end else if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= '0;
            if (item_type == REQ_INSERT) begin
              m_tuser <= STATUS_FULL;
            end else if (empty) begin
              m_tuser <= STATUS_EMPTY;
            end else begin
              m_tuser <= STATUS_TAKEN;
              m_tdata <= {cell_q[0].sec, cell_q[0].cyl, cell_q[0].tag};
              count   <= count - CNT_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        ST_CALC: begin
          mod_cnt <= '0;
          state   <= ST_MOD;
        end
        ST_MOD: begin
          mod_cnt <= mod_cnt + MOD_CNT_W'(1);
          if (mod_cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= STATUS_INSERTED;
            m_tdata  <= '0;
            count    <= count + CNT_W'(1);
            state    <= ST_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // a committed take removes exactly one entry
  a_take_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && out_free && item_type == REQ_TAKE && !empty)
      |=> (count == $past(count) - CNT_W'(1)))
    else $error("take did not lower the count by one");

  // some cell always claims the new request when the insert commits
  a_slot_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> found[QUEUE_DEPTH])
    else $error("no slot found for insert");

  // an insert commit shows up as an inserted status on the next cycle
  a_insert_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && out_free)
      |=> (m_tvalid && m_tuser == STATUS_INSERTED))
    else $error("insert commit without inserted result");
`endif

endmodule
